[hw/rtl/xor_checked_packet_receiver_ack_defines.svh]
// Assertion macros shared by the receiver modules. They use the clk and
// rst_n signals of the module in which they appear.
`ifndef XOR_CHECKED_PACKET_RECEIVER_ACK_DEFINES_SVH
`define XOR_CHECKED_PACKET_RECEIVER_ACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XCPR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XCPR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/xcpr_pkg.sv]
`default_nettype none

package xcpr_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [2:0] status;
        logic [7:0] frame_identifier;
        logic [7:0] frame_length;
        logic [7:0] data_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first_header;
        logic [7:0] second_header;
        logic [7:0] buffer_size;
        logic       clear_on_receive;
    } cfg_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [2:0] status;
        logic [7:0] ident;
        logic [7:0] length;
        logic [7:0] data;
    } cmd_t;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_SENT = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] OUT_STATUS = 2'd0;
    localparam logic [1:0] OUT_ACK    = 2'd1;
    localparam logic [1:0] OUT_READ   = 2'd2;

    localparam logic [2:0] ST_DATA_OK  = 3'd0;
    localparam logic [2:0] ST_ACK_OK   = 3'd1;
    localparam logic [2:0] ST_ACK_BAD  = 3'd2;
    localparam logic [2:0] ST_DATA_BAD = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [1:0] REG_BUFFER_SIZE   = 2'd2;
    localparam logic [1:0] REG_CLEAR_ON_RX   = 2'd3;

    localparam logic [2:0] BEAT_HEADER1 = 3'd0;
    localparam logic [2:0] BEAT_HEADER2 = 3'd1;
    localparam logic [2:0] BEAT_ZERO_A  = 3'd2;
    localparam logic [2:0] BEAT_ZERO_B  = 3'd3;
    localparam logic [2:0] BEAT_ONE     = 3'd4;
    localparam logic [2:0] BEAT_CSUM    = 3'd5;
    localparam logic [2:0] BEAT_CSUM_X  = 3'd6;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

endpackage

`default_nettype wire

[hw/rtl/xcpr_front.sv]
`default_nettype none

`include "xor_checked_packet_receiver_ack_defines.svh"

module xcpr_front #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire xcpr_pkg::cfg_t     cfg,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire xcpr_pkg::in_item_t item,
    output logic                    cmd_push,
    input  wire logic               cmd_full,
    output xcpr_pkg::cmd_t          cmd
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_SECOND  = 6'b000010,
        PH_IDENT   = 6'b000100,
        PH_ACKFLAG = 6'b001000,
        PH_LENGTH  = 6'b010000,
        PH_BODY    = 6'b100000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      ident_reg, ident_next;
    logic            ack_reg, ack_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      count_reg, count_next;
    logic [7:0]      csum_reg, csum_next;
    logic [7:0]      sent_reg, sent_next;
    logic [7:0]      byte0_reg, byte0_next;

    logic            s1_valid_reg;
    xcpr_pkg::cmd_t  s1_cmd_reg;

    logic [BUFFER_DEPTH-1:0] marks_reg;
    logic [7:0]      mem [BUFFER_DEPTH];
    logic [7:0]      rd_data_reg;
    logic            rd_ok_reg;

    logic            accept;
    logic            gen;
    xcpr_pkg::cmd_t  gen_cmd;
    logic            clear_marks;
    logic            wr_en;
    logic            rd_en;
    logic            good;
    logic [7:0]      b;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            rd_in_range;

    assign b           = item.byte_value;
    assign item_ready  = !s1_valid_reg || !cmd_full;
    assign accept      = item_valid && item_ready;
    assign cmd_push    = s1_valid_reg && !cmd_full;
    assign good        = (csum_reg == b);
    assign wr_addr     = count_reg[AW-1:0];
    assign rd_addr     = item.read_index[AW-1:0];
    assign rd_in_range = ({1'b0, item.read_index} < DEPTH_W);

    always_comb
    begin
        phase_next  = phase_reg;
        ident_next  = ident_reg;
        ack_next    = ack_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        csum_next   = csum_reg;
        sent_next   = sent_reg;
        byte0_next  = byte0_reg;
        gen         = 1'b0;
        gen_cmd     = '0;
        clear_marks = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (accept)
        begin
            case (item.kind)
                xcpr_pkg::KIND_SENT:
                begin
                    sent_next = b;
                end
                xcpr_pkg::KIND_READ:
                begin
                    rd_en            = 1'b1;
                    gen              = 1'b1;
                    gen_cmd.out_kind = xcpr_pkg::OUT_READ;
                end
                xcpr_pkg::KIND_RX:
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (b == cfg.first_header)
                            begin
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND:
                        begin
                            phase_next = (b == cfg.second_header) ? PH_IDENT : PH_HUNT;
                        end
                        PH_IDENT:
                        begin
                            ident_next = b;
                            phase_next = PH_ACKFLAG;
                        end
                        PH_ACKFLAG:
                        begin
                            ack_next   = (b != 8'd0);
                            phase_next = PH_LENGTH;
                        end
                        PH_LENGTH:
                        begin
                            len_next   = b;
                            phase_next = PH_HUNT;
                            if (b != 8'd0)
                            begin
                                clear_marks = cfg.clear_on_receive;
                                if (b > cfg.buffer_size)
                                begin
                                    gen              = 1'b1;
                                    gen_cmd.out_kind = xcpr_pkg::OUT_STATUS;
                                    gen_cmd.status   = xcpr_pkg::ST_TOO_LONG;
                                    gen_cmd.ident    = ident_reg;
                                    gen_cmd.length   = b;
                                end
                                else
                                begin
                                    count_next = 8'd0;
                                    csum_next  = b;
                                    phase_next = PH_BODY;
                                end
                            end
                        end
                        PH_BODY:
                        begin
                            wr_en = ({1'b0, count_reg} < DEPTH_W);
                            if (count_reg < len_reg)
                            begin
                                csum_next  = csum_reg ^ b;
                                count_next = count_reg + 8'd1;
                                if (count_reg == 8'd0)
                                begin
                                    byte0_next = b;
                                end
                            end
                            else
                            begin
                                phase_next     = PH_HUNT;
                                count_next     = 8'd0;
                                gen            = 1'b1;
                                gen_cmd.ident  = ident_reg;
                                gen_cmd.length = len_reg;
                                if (ident_reg != 8'd0)
                                begin
                                    if (!good)
                                    begin
                                        gen_cmd.out_kind = xcpr_pkg::OUT_STATUS;
                                        gen_cmd.status   = xcpr_pkg::ST_DATA_BAD;
                                    end
                                    else if (!ack_reg)
                                    begin
                                        gen_cmd.out_kind = xcpr_pkg::OUT_STATUS;
                                        gen_cmd.status   = xcpr_pkg::ST_DATA_OK;
                                    end
                                    else
                                    begin
                                        gen_cmd.out_kind = xcpr_pkg::OUT_ACK;
                                        gen_cmd.status   = xcpr_pkg::ST_DATA_OK;
                                        gen_cmd.data     = b;
                                    end
                                end
                                else
                                begin
                                    gen_cmd.out_kind = xcpr_pkg::OUT_STATUS;
                                    gen_cmd.status   = (good && (byte0_reg == sent_reg)) ?
                                                       xcpr_pkg::ST_ACK_OK :
                                                       xcpr_pkg::ST_ACK_BAD;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            ident_reg    <= 8'd0;
            ack_reg      <= 1'b0;
            len_reg      <= 8'd0;
            count_reg    <= 8'd0;
            csum_reg     <= 8'd0;
            sent_reg     <= 8'd0;
            byte0_reg    <= 8'd0;
            s1_valid_reg <= 1'b0;
            marks_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ident_reg <= ident_next;
            ack_reg   <= ack_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            csum_reg  <= csum_next;
            sent_reg  <= sent_next;
            byte0_reg <= byte0_next;
            if (gen)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (cmd_push)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (clear_marks)
            begin
                marks_reg <= '0;
            end
            else if (wr_en)
            begin
                marks_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            s1_cmd_reg <= gen_cmd;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= b;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= rd_in_range && marks_reg[rd_addr];
        end
    end

    always_comb
    begin
        cmd = s1_cmd_reg;
        if (s1_cmd_reg.out_kind == xcpr_pkg::OUT_READ)
        begin
            cmd.data = rd_ok_reg ? rd_data_reg : 8'd0;
        end
    end

    `XCPR_ASSERT_NOW(a_front_accept_room, accept && gen, !s1_valid_reg || cmd_push, "Front stage overwritten before its command was queued.")
    `XCPR_ASSERT_NEXT(a_front_stage_holds, s1_valid_reg && !cmd_push, s1_valid_reg, "Front stage lost a command while the queue was full.")

endmodule

`default_nettype wire

[hw/rtl/xcpr_fifo.sv]
`default_nettype none

`include "xor_checked_packet_receiver_ack_defines.svh"

module xcpr_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire xcpr_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output xcpr_pkg::cmd_t       head_cmd
);

    localparam logic [xcpr_pkg::Q_AW:0] DEPTH_W = (xcpr_pkg::Q_AW + 1)'(xcpr_pkg::Q_DEPTH);

    xcpr_pkg::cmd_t              entries [xcpr_pkg::Q_DEPTH];
    logic [xcpr_pkg::Q_AW-1:0]   wr_ptr_reg;
    logic [xcpr_pkg::Q_AW-1:0]   rd_ptr_reg;
    logic [xcpr_pkg::Q_AW:0]     count_reg;

    assign full       = (count_reg == DEPTH_W);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    `XCPR_ASSERT_NOW(a_fifo_no_overflow, push, !full, "Command pushed into a full queue.")
    `XCPR_ASSERT_NOW(a_fifo_no_underflow, pop, head_valid, "Command popped from an empty queue.")

endmodule

`default_nettype wire

[hw/rtl/xcpr_back.sv]
`default_nettype none

`include "xor_checked_packet_receiver_ack_defines.svh"

module xcpr_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire xcpr_pkg::cfg_t  cfg,
    input  wire logic            head_valid,
    input  wire xcpr_pkg::cmd_t  head_cmd,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output xcpr_pkg::out_item_t  result
);

    logic                  valid_reg;
    xcpr_pkg::out_item_t   result_reg, result_next;
    logic [2:0]            beat_reg, beat_next;
    logic                  load;
    logic                  is_ack;
    logic                  last_beat;
    logic [7:0]            ack_byte;

    assign is_ack       = (head_cmd.out_kind == xcpr_pkg::OUT_ACK);
    assign last_beat    = !is_ack || (beat_reg == xcpr_pkg::BEAT_CSUM_X);
    assign load         = head_valid && (!valid_reg || result_ready);
    assign pop          = load && last_beat;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        unique case (beat_reg)
            xcpr_pkg::BEAT_HEADER1: ack_byte = cfg.first_header;
            xcpr_pkg::BEAT_HEADER2: ack_byte = cfg.second_header;
            xcpr_pkg::BEAT_ZERO_A:  ack_byte = 8'd0;
            xcpr_pkg::BEAT_ZERO_B:  ack_byte = 8'd0;
            xcpr_pkg::BEAT_ONE:     ack_byte = 8'd1;
            xcpr_pkg::BEAT_CSUM:    ack_byte = head_cmd.data;
            xcpr_pkg::BEAT_CSUM_X:  ack_byte = head_cmd.data ^ 8'd1;
            default:                ack_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        result_next.out_kind         = head_cmd.out_kind;
        result_next.status           = head_cmd.status;
        result_next.frame_identifier = head_cmd.ident;
        result_next.frame_length     = head_cmd.length;
        result_next.data_byte        = is_ack ? ack_byte : head_cmd.data;
        result_next.last             = last_beat;
        beat_next = beat_reg;
        if (load)
        begin
            beat_next = last_beat ? 3'd0 : beat_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= 3'd0;
        end
        else
        begin
            beat_reg <= beat_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    `XCPR_ASSERT_NOW(a_back_beat_in_ack, beat_reg != 3'd0, head_valid && is_ack, "Ack beat count is running without an ack command at the head.")
    `XCPR_ASSERT_NOW(a_back_pop_on_last, pop, result_next.last, "Command popped before its final result.")

endmodule

`default_nettype wire

[hw/rtl/xor_checked_packet_receiver_ack.sv]
// Framed byte receiver with XOR checksum and ack reply. Input items are
// accepted at up to one per clock cycle unless the front stage holds a
// command the full queue cannot take: the parser, running checksum and
// buffer write complete in the cycle an item is taken, and a four-entry
// command queue between the parser and result stage lets the input keep
// flowing while results wait. Results leave the output register one per
// cycle while result_ready is high; a good data frame asking for an ack
// yields seven results, so back-to-back acked frames are limited by the
// output side to one result per cycle. Read data is registered, then
// passes the queue and output register. No clearing pass after reset.
`default_nettype none

module xor_checked_packet_receiver_ack #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire xcpr_pkg::in_item_t   item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output xcpr_pkg::out_item_t       result
);

    xcpr_pkg::cfg_t  cfg_reg;
    logic            cmd_push;
    logic            cmd_full;
    xcpr_pkg::cmd_t  cmd;
    logic            cmd_pop;
    logic            head_valid;
    xcpr_pkg::cmd_t  head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_header     <= 8'd0;
            cfg_reg.second_header    <= 8'd0;
            cfg_reg.buffer_size      <= 8'd255;
            cfg_reg.clear_on_receive <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                xcpr_pkg::REG_FIRST_HEADER:  cfg_reg.first_header     <= cfg_data;
                xcpr_pkg::REG_SECOND_HEADER: cfg_reg.second_header    <= cfg_data;
                xcpr_pkg::REG_BUFFER_SIZE:   cfg_reg.buffer_size      <= cfg_data;
                xcpr_pkg::REG_CLEAR_ON_RX:   cfg_reg.clear_on_receive <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    xcpr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_push   (cmd_push),
        .cmd_full   (cmd_full),
        .cmd        (cmd)
    );

    xcpr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    xcpr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (cmd_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire
